FILE: src/bmmd_pkg.sv
`timescale 1ns / 1ps

package bmmd_pkg;

   // Region codes reported on the result channel.
   localparam logic [3:0] REGION_ROM      = 4'd0;
   localparam logic [3:0] REGION_VRAM     = 4'd1;
   localparam logic [3:0] REGION_CART_RAM = 4'd2;
   localparam logic [3:0] REGION_WRAM     = 4'd3;
   localparam logic [3:0] REGION_OAM      = 4'd4;
   localparam logic [3:0] REGION_WAVE     = 4'd5;
   localparam logic [3:0] REGION_HRAM     = 4'd6;
   localparam logic [3:0] REGION_IO       = 4'd7;
   localparam logic [3:0] REGION_BANK_CTL = 4'd8;

   // Bank controller types.
   localparam logic [2:0] CTRL_NONE = 3'd0;
   localparam logic [2:0] CTRL_MBC1 = 3'd1;
   localparam logic [2:0] CTRL_MBC2 = 3'd2;
   localparam logic [2:0] CTRL_MBC3 = 3'd3;
   localparam logic [2:0] CTRL_MBC5 = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 18;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTROLLER_TYPE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CART_RAM_BYTES  = 1'd1;

   // Access kinds.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Address map boundaries.
   localparam logic [15:0] ECHO_BASE     = 16'hE000;
   localparam logic [15:0] ECHO_LAST     = 16'hFDFF;
   localparam logic [15:0] ECHO_DISTANCE = 16'h2000;
   localparam logic [15:0] VRAM_BASE     = 16'h8000;
   localparam logic [15:0] CART_BASE     = 16'hA000;
   localparam logic [15:0] WRAM_BASE     = 16'hC000;
   localparam logic [15:0] OAM_BASE      = 16'hFE00;
   localparam logic [15:0] OAM_LAST      = 16'hFE9F;
   localparam logic [15:0] WAVE_BASE     = 16'hFF30;
   localparam logic [15:0] WAVE_LAST     = 16'hFF3F;
   localparam logic [15:0] HRAM_BASE     = 16'hFF80;
   localparam logic [15:0] HRAM_LAST     = 16'hFFFE;

   // Bank control windows inside the ROM area.
   localparam logic [15:0] ROM_SEL_BASE  = 16'h2000;
   localparam logic [15:0] ROM_SEL_LAST  = 16'h4000;
   localparam logic [15:0] MBC5_SEL_LAST = 16'h3000;
   localparam logic [15:0] MBC2_SEL_BASE = 16'h2100;
   localparam logic [15:0] MBC2_SEL_LAST = 16'h2200;
   localparam logic [15:0] RAM_SEL_BASE  = 16'h4000;
   localparam logic [15:0] RAM_SEL_LAST  = 16'h6000;

   localparam logic [7:0] ROM_BANK_RESET = 8'd1;
   localparam logic [7:0] RAM_BANK_RESET = 8'd0;

   typedef struct packed {
      logic        func;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        vram_bank;
      logic [2:0]  wram_bank;
   } req_type;

   typedef struct packed {
      logic [3:0]  region;
      logic [21:0] offset;
      logic        store_write;
      logic [7:0]  data_out;
      logic        open_bus;
   } rsp_type;

   // Bank register update requested by one access.
   typedef struct packed {
      logic       rom_we;
      logic [7:0] rom_value;
      logic       ram_we;
      logic [7:0] ram_value;
   } bank_update_type;

endpackage

FILE: src/bmmd_decode.sv
`timescale 1ns / 1ps

module bmmd_decode (
   input  bmmd_pkg::req_type         item,
   input  logic [2:0]                controller_type,
   input  logic [17:0]               cart_ram_bytes,
   input  logic [7:0]                rom_bank,
   input  logic [7:0]                cart_ram_bank,
   output bmmd_pkg::rsp_type         result,
   output bmmd_pkg::bank_update_type bank_update
);
   import bmmd_pkg::*;

   logic [15:0] addr;
   logic [20:0] cart_offset;
   logic [2:0]  wram_sel;
   logic        is_write;
   logic        in_rom_sel;
   logic        in_ram_sel;

   // Echo RAM folds onto work RAM.
   always_comb begin
      if (item.address >= ECHO_BASE && item.address <= ECHO_LAST) begin
         addr = item.address - ECHO_DISTANCE;
      end else begin
         addr = item.address;
      end
   end

   assign is_write    = (item.func == FUNC_WRITE);
   assign cart_offset = {cart_ram_bank, addr[12:0]};
   assign wram_sel    = (item.wram_bank == 3'd0) ? 3'd1 : item.wram_bank;
   assign in_rom_sel  = (addr >= ROM_SEL_BASE) && (addr < ROM_SEL_LAST);
   assign in_ram_sel  = (addr >= RAM_SEL_BASE) && (addr < RAM_SEL_LAST);

   always_comb begin
      result.region      = REGION_IO;
      result.offset      = {6'd0, addr};
      result.store_write = item.func;
      result.data_out    = is_write ? item.write_data : 8'd0;
      result.open_bus    = 1'b0;

      if (addr < VRAM_BASE) begin
         if (is_write) begin
            result.region      = REGION_BANK_CTL;
            result.store_write = 1'b0;
         end else begin
            result.region = REGION_ROM;
            if (addr[14]) begin
               result.offset = {rom_bank, addr[13:0]};
            end
         end
      end else if (addr < CART_BASE) begin
         result.region = REGION_VRAM;
         result.offset = {8'd0, item.vram_bank, addr[12:0]};
      end else if (addr < WRAM_BASE) begin
         result.region = REGION_CART_RAM;
         result.offset = {1'b0, cart_offset};
         if (cart_offset >= {3'd0, cart_ram_bytes}) begin
            result.open_bus    = 1'b1;
            result.store_write = 1'b0;
         end
      end else if (addr < ECHO_BASE) begin
         result.region = REGION_WRAM;
         if (addr[12]) begin
            result.offset = {7'd0, wram_sel, addr[11:0]};
         end else begin
            result.offset = {10'd0, addr[11:0]};
         end
      end else if (addr >= OAM_BASE && addr <= OAM_LAST) begin
         result.region = REGION_OAM;
         result.offset = {6'd0, addr - OAM_BASE};
      end else if (addr >= WAVE_BASE && addr <= WAVE_LAST) begin
         result.region = REGION_WAVE;
         result.offset = {6'd0, addr - WAVE_BASE};
      end else if (addr >= HRAM_BASE && addr <= HRAM_LAST) begin
         result.region = REGION_HRAM;
         result.offset = {6'd0, addr - HRAM_BASE};
      end
   end

   // Bank register writes through the ROM window.
   always_comb begin
      bank_update.rom_we    = 1'b0;
      bank_update.rom_value = item.write_data;
      bank_update.ram_we    = 1'b0;
      bank_update.ram_value = item.write_data;
      if (is_write && addr < VRAM_BASE) begin
         case (controller_type)
            CTRL_MBC1: begin
               if (in_rom_sel) begin
                  bank_update.rom_we = 1'b1;
                  if (item.write_data == 8'd0) begin
                     bank_update.rom_value = 8'd1;
                  end
               end else if (in_ram_sel) begin
                  bank_update.ram_we = 1'b1;
               end
            end
            CTRL_MBC2: begin
               bank_update.rom_we = (addr >= MBC2_SEL_BASE) && (addr < MBC2_SEL_LAST);
            end
            CTRL_MBC3: begin
               bank_update.rom_we = in_rom_sel;
               bank_update.ram_we = in_ram_sel;
            end
            CTRL_MBC5: begin
               bank_update.rom_we = (addr >= ROM_SEL_BASE) && (addr < MBC5_SEL_LAST);
               bank_update.ram_we = in_ram_sel;
            end
            default: begin
               bank_update.rom_we = 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: src/banked_memory_map_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   bmmd_pkg::req_type (one bus access)
// rsp_      out        rsp_valid/rsp_stall   bmmd_pkg::rsp_type (region, offset, flags)
// csr_      in         csr_valid/csr_ready   csr_index, csr_data (register write)
//
// One beat is taken per cycle while req_stall is low, set by the single decode pass
// between two registers. A request beat enters the input register when accepted and is
// decoded into the result register once that register is free, where its result is
// offered. Bank register updates land with that move, so the next beat already sees them.
// Reset is synchronous and active high; it empties both stages, clears the configuration
// and sets the ROM bank to 1 and the cartridge RAM bank to 0. When rsp_stall holds the
// result register, the input register still takes one beat.
module banked_memory_map_decoder_top (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  bmmd_pkg::req_type                           req_payload,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output bmmd_pkg::rsp_type                           rsp_payload,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [bmmd_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [bmmd_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);
   import bmmd_pkg::*;

   // Input stage.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_item_ff;
   req_type         in_item_in;

   // Result stage.
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_type         out_item_ff;
   rsp_type         out_item_in;

   // Configuration and bank state.
   logic [2:0]      ctrl_type_ff;
   logic [2:0]      ctrl_type_in;
   logic [17:0]     ram_bytes_ff;
   logic [17:0]     ram_bytes_in;
   logic [7:0]      rom_bank_ff;
   logic [7:0]      rom_bank_in;
   logic [7:0]      ram_bank_ff;
   logic [7:0]      ram_bank_in;

   logic            out_free;
   logic            advance;
   logic            req_take;
   logic            csr_take;
   rsp_type         decoded;
   bank_update_type bank_update;

   bmmd_decode u_decode (
      .item            (in_item_ff),
      .controller_type (ctrl_type_ff),
      .cart_ram_bytes  (ram_bytes_ff),
      .rom_bank        (rom_bank_ff),
      .cart_ram_bank   (ram_bank_ff),
      .result          (decoded),
      .bank_update     (bank_update)
   );

   // The result register frees up when it is empty or its beat leaves this cycle.
   // The input register moves forward whenever the result register is free, so it
   // only stalls the requester when it is full and the result side is blocked.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      rom_bank_in  = rom_bank_ff;
      ram_bank_in  = ram_bank_ff;
      ctrl_type_in = ctrl_type_ff;
      ram_bytes_in = ram_bytes_ff;

      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_item_in = decoded;
         // Bank writes commit as the access leaves the input register, in beat order.
         if (bank_update.rom_we) begin
            rom_bank_in = bank_update.rom_value;
         end
         if (bank_update.ram_we) begin
            ram_bank_in = bank_update.ram_value;
         end
      end

      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (csr_take) begin
         case (csr_index)
            CSR_CONTROLLER_TYPE: ctrl_type_in = csr_data[2:0];
            CSR_CART_RAM_BYTES:  ram_bytes_in = csr_data;
            default:             ctrl_type_in = ctrl_type_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_type_ff <= CTRL_NONE;
         ram_bytes_ff <= 18'd0;
         rom_bank_ff  <= ROM_BANK_RESET;
         ram_bank_ff  <= RAM_BANK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctrl_type_ff <= ctrl_type_in;
         ram_bytes_ff <= ram_bytes_in;
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // Without a bank controller the bank registers never move.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_type_ff == CTRL_NONE) |=> ($stable(rom_bank_ff) && $stable(ram_bank_ff)))
      else $error("bank register changed with no bank controller");

   // A write into the ROM area leaves as a bank control result that stores nothing.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.func == FUNC_WRITE && in_item_ff.address < VRAM_BASE)
      |=> (out_valid_ff && out_item_ff.region == REGION_BANK_CTL
           && !out_item_ff.store_write))
      else $error("ROM area write did not become a bank control result");

   // Out-of-range cartridge RAM is only flagged for cartridge RAM and never stored.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.open_bus)
      |-> (out_item_ff.region == REGION_CART_RAM && !out_item_ff.store_write))
      else $error("open bus flagged outside cartridge RAM or with a store");

   // The requester is held off only while the input register is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full blocked pipeline");

endmodule
